FILE: rtl/zcfc_pkg.sv
package zcfc_pkg;

	// Field and register widths
	localparam int SAMPLE_W    = 16;
	localparam int THR_W       = 15;
	localparam int SR_W        = 27;
	localparam int FREQ_W      = 38;
	localparam int CNT_W       = 32;
	localparam int CFG_W       = 27;
	localparam int CFG_ADDR_W  = 1;
	localparam int IN_TDATA_W  = 16;
	localparam int OUT_TDATA_W = 40;

	// Frequency scale: 1/256 Hz units
	localparam int FRAC_SHIFT = 8;

	// Defaults
	localparam int CYCLES_DEF = 10;

	localparam logic [THR_W-1:0]  THR_RST  = 15'd1000;
	localparam logic [SR_W-1:0]   SR_RST   = 27'd48000;
	localparam logic [FREQ_W-1:0] FREQ_MAX = {FREQ_W{1'b1}};

	// Configuration register indexes
	typedef enum logic [CFG_ADDR_W-1:0] {
		REG_THRESHOLD   = 1'b0,
		REG_SAMPLE_RATE = 1'b1
	} reg_idx_t;

	// Controller states
	typedef enum logic {
		ST_IDLE = 1'b0,
		ST_DIV  = 1'b1
	} state_t;

	// Controller to datapath
	typedef struct packed {
		logic accept;
		logic div_run;
		logic load_out;
	} zcfc_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic measure;
		logic div_last;
	} zcfc_sts_t;

endpackage

FILE: rtl/zcfc_ctrl.sv
module zcfc_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	output logic               m_tvalid,
	input  logic               m_tready,
	input  zcfc_pkg::zcfc_sts_t sts,
	output zcfc_pkg::zcfc_cmd_t cmd
);

	zcfc_pkg::state_t state_q, state_d;
	logic             out_valid_q;
	logic             accept;

	// State and output valid registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= zcfc_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Take a beat only when idle and the output slot is empty or frees up this cycle
	assign s_tready = (state_q == zcfc_pkg::ST_IDLE) && (!out_valid_q || m_tready);
	assign accept   = s_tvalid && s_tready;
	assign m_tvalid = out_valid_q;

	// Next state and commands
	always_comb begin
		state_d      = state_q;
		cmd.accept   = accept;
		cmd.div_run  = 1'b0;
		cmd.load_out = 1'b0;
		unique case (state_q)
			zcfc_pkg::ST_IDLE: begin
				if (accept) begin
					if (sts.measure) begin
						state_d = zcfc_pkg::ST_DIV;
					end else begin
						cmd.load_out = 1'b1;
					end
				end
			end
			zcfc_pkg::ST_DIV: begin
				cmd.div_run = 1'b1;
				if (sts.div_last) begin
					cmd.load_out = 1'b1;
					state_d      = zcfc_pkg::ST_IDLE;
				end
			end
		endcase
	end

endmodule

FILE: rtl/zcfc_dp.sv
module zcfc_dp #(
	parameter int CYCLES = zcfc_pkg::CYCLES_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [zcfc_pkg::CFG_ADDR_W-1:0]     cfg_addr,
	input  logic [zcfc_pkg::CFG_W-1:0]          cfg_data,
	input  logic [zcfc_pkg::SAMPLE_W-1:0]       sample,
	output logic [zcfc_pkg::FREQ_W-1:0]         frequency,
	input  zcfc_pkg::zcfc_cmd_t                 cmd,
	output zcfc_pkg::zcfc_sts_t                 sts
);

	localparam int CYC_W  = $clog2(CYCLES + 1);
	localparam int NUM_W  = CYC_W + zcfc_pkg::SR_W + zcfc_pkg::FRAC_SHIFT;
	localparam int DEN_W  = zcfc_pkg::CNT_W + 1;
	localparam int REM_W  = DEN_W;
	localparam int STEP_W = $clog2(NUM_W);
	localparam int QW     = (NUM_W > zcfc_pkg::FREQ_W) ? NUM_W : zcfc_pkg::FREQ_W;
	localparam int MAG_W  = zcfc_pkg::SAMPLE_W + 1;

	logic [zcfc_pkg::THR_W-1:0]  thr_q;
	logic [zcfc_pkg::SR_W-1:0]   sr_q;
	logic                        sign_q;
	logic [CYC_W-1:0]            cyc_q;
	logic [zcfc_pkg::CNT_W-1:0]  cnt_q;
	logic [zcfc_pkg::FREQ_W-1:0] held_q;
	logic [zcfc_pkg::FREQ_W-1:0] out_q;

	logic [REM_W-1:0]  rem_q;
	logic [NUM_W-1:0]  quo_q;
	logic [DEN_W-1:0]  den_q;
	logic [STEP_W-1:0] step_q;

	logic                        neg;
	logic [MAG_W-1:0]            mag;
	logic                        pass;
	logic                        pos;
	logic                        rise;
	logic [CYC_W:0]              cyc_inc;
	logic                        measure;
	logic [NUM_W-1:0]            num;
	logic [REM_W:0]              shifted;
	logic [REM_W:0]              diff;
	logic                        ge;
	logic [REM_W-1:0]            rem_next;
	logic [NUM_W-1:0]            quo_next;
	logic [QW-1:0]               q_ext;
	logic [zcfc_pkg::FREQ_W-1:0] frq_sat;

	// Crossing detection on the incoming sample
	assign neg     = sample[zcfc_pkg::SAMPLE_W-1];
	assign mag     = neg ? (MAG_W'(1) << zcfc_pkg::SAMPLE_W) - {1'b0, sample}
	                     : {1'b0, sample};
	assign pass    = mag >= MAG_W'(thr_q);
	assign pos     = !neg && (sample != '0);
	assign rise    = pass && pos && !sign_q;
	assign cyc_inc = {1'b0, cyc_q} + (CYC_W + 1)'(1);
	assign measure = rise && (cyc_inc >= (CYC_W + 1)'(CYCLES));

	assign sts.measure = measure;

	// Scaled numerator: CYCLES * sample_rate * 256
	assign num = (NUM_W'(sr_q) * NUM_W'(CYCLES)) << zcfc_pkg::FRAC_SHIFT;

	// One restoring division step
	assign shifted  = {rem_q, quo_q[NUM_W-1]};
	assign ge       = shifted >= (REM_W + 1)'(den_q);
	assign diff     = shifted - (REM_W + 1)'(den_q);
	assign rem_next = ge ? diff[REM_W-1:0] : shifted[REM_W-1:0];
	assign quo_next = {quo_q[NUM_W-2:0], ge};

	assign sts.div_last = (step_q == '0);

	// Clamp the quotient to the frequency field
	assign q_ext   = QW'(quo_next);
	assign frq_sat = (q_ext > QW'(zcfc_pkg::FREQ_MAX)) ? zcfc_pkg::FREQ_MAX
	                                                 : zcfc_pkg::FREQ_W'(q_ext);

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= zcfc_pkg::THR_RST;
			sr_q  <= zcfc_pkg::SR_RST;
		end else if (cfg_we) begin
			unique case (zcfc_pkg::reg_idx_t'(cfg_addr))
				zcfc_pkg::REG_THRESHOLD:   thr_q <= cfg_data[zcfc_pkg::THR_W-1:0];
				zcfc_pkg::REG_SAMPLE_RATE: sr_q  <= cfg_data[zcfc_pkg::SR_W-1:0];
			endcase
		end
	end

	// Sign, counters and held frequency
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sign_q <= 1'b1;
			cyc_q  <= '0;
			cnt_q  <= '0;
			held_q <= '0;
		end else begin
			if (cmd.accept) begin
				if (pass) begin
					sign_q <= pos;
				end
				if (measure) begin
					cyc_q <= '0;
				end else if (rise) begin
					cyc_q <= cyc_inc[CYC_W-1:0];
				end
				if (measure) begin
					cnt_q <= '0;
				end else if (cnt_q != '1) begin
					cnt_q <= cnt_q + 1'b1;
				end
			end
			if (cmd.div_run && sts.div_last) begin
				held_q <= frq_sat;
			end
		end
	end

	// Divider registers: load on a measuring beat, then shift one bit a cycle
	always_ff @(posedge clk) begin
		if (cmd.accept && measure) begin
			rem_q  <= '0;
			quo_q  <= num;
			den_q  <= DEN_W'(cnt_q) + DEN_W'(1);
			step_q <= STEP_W'(NUM_W - 1);
		end else if (cmd.div_run) begin
			rem_q  <= rem_next;
			quo_q  <= quo_next;
			step_q <= step_q - 1'b1;
		end
	end

	// Output data register
	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_q <= cmd.div_run ? frq_sat : held_q;
		end
	end

	assign frequency = out_q;

endmodule

FILE: rtl/zero_crossing_frequency_counter_unit.sv
// A sample that does not close a measurement is shown in the cycle after its beat.
// A sample that closes a measurement runs a bit-serial divider, and its result is loaded
// into the output register when the last divider step is done; no beat is taken meanwhile.
// Throughput: one sample per cycle between measurements while m_tready holds, set by the output register.
// Reset (arst_n low, asynchronous): threshold 1000, sample rate 48000, sign positive,
// counters and held frequency zero, no output pending.
module zero_crossing_frequency_counter_unit #(
	parameter int CYCLES = zcfc_pkg::CYCLES_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [zcfc_pkg::CFG_ADDR_W-1:0]     cfg_addr,
	input  logic [zcfc_pkg::CFG_W-1:0]          cfg_data,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [zcfc_pkg::IN_TDATA_W-1:0]     s_tdata,   // [15:0] sample
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [zcfc_pkg::OUT_TDATA_W-1:0]    m_tdata    // [37:0] frequency, [39:38] zero
);

	zcfc_pkg::zcfc_cmd_t         cmd;
	zcfc_pkg::zcfc_sts_t         sts;
	logic [zcfc_pkg::FREQ_W-1:0] frequency;

	zcfc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	zcfc_dp #(
		.CYCLES (CYCLES)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_data  (cfg_data),
		.sample    (s_tdata[zcfc_pkg::SAMPLE_W-1:0]),
		.frequency (frequency),
		.cmd       (cmd),
		.sts       (sts)
	);

	// Pad the frequency to whole bytes
	assign m_tdata = zcfc_pkg::OUT_TDATA_W'(frequency);

endmodule

FILE: rtl/zcfc_chk.sv
module zcfc_chk (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             s_tvalid,
	input logic                             s_tready,
	input logic                             m_tvalid,
	input logic                             m_tready,
	input logic [zcfc_pkg::OUT_TDATA_W-1:0] m_tdata
);

	// No new beat while a result is stuck at the output
	a_block_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |-> !s_tready)
		else $error("input taken while output stalled");

	// An accepted beat either shows a result or holds off input for the divider
	a_beat_answered: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> (m_tvalid || !s_tready))
		else $error("accepted beat neither answered nor dividing");

	// Padding bits stay zero
	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[zcfc_pkg::OUT_TDATA_W-1:zcfc_pkg::FREQ_W] == '0))
		else $error("output padding not zero");

	// A stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
		else $error("stalled output changed");

endmodule

bind zero_crossing_frequency_counter_unit zcfc_chk u_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

FILE: tb/tb_top.sv
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int N_CYCLES   = zcfc_pkg::CYCLES_DEF;
	localparam int STALL_PCT  = 12;
	localparam int IDLE_LIMIT = 1000;
	localparam int TAIL_WAIT  = 60;

	logic                             clk;
	logic                             arst_n;
	logic                             cfg_we;
	zcfc_pkg::reg_idx_t               cfg_addr;
	logic [zcfc_pkg::CFG_W-1:0]       cfg_data;
	logic                             s_tvalid;
	logic                             s_tready;
	logic [zcfc_pkg::IN_TDATA_W-1:0]  s_tdata;   // [15:0] sample
	logic                             m_tvalid;
	logic                             m_tready;
	logic [zcfc_pkg::OUT_TDATA_W-1:0] m_tdata;   // [37:0] frequency, [39:38] zero

	// Predictor copy of the registers and state
	logic [zcfc_pkg::THR_W-1:0]  thr_q;
	logic [zcfc_pkg::SR_W-1:0]   rate_q;
	logic                        sign_pos_q;
	logic [3:0]                  cross_cnt_q;
	logic [zcfc_pkg::CNT_W-1:0]  smp_cnt_q;
	logic [zcfc_pkg::FREQ_W-1:0] held_freq_q;

	logic [zcfc_pkg::FREQ_W-1:0] freq_expect_q[$];
	int                          fail_count;
	int                          quiet_cycles;
	logic                        calm;

	zero_crossing_frequency_counter_unit #(
		.CYCLES(N_CYCLES)
	) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_addr (cfg_addr),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always #1 clk = ~clk;

	// Advance the predictor by one sample and return the frequency it shows
	function automatic logic [zcfc_pkg::FREQ_W-1:0] next_frequency(
		input logic [zcfc_pkg::SAMPLE_W-1:0] smp
	);
		logic        neg;
		logic        pos;
		logic        rise;
		logic        measured;
		logic [16:0] mag;
		logic [63:0] num;
		logic [63:0] den;
		logic [63:0] quo;
		neg      = smp[zcfc_pkg::SAMPLE_W-1];
		mag      = neg ? (17'h10000 - {1'b0, smp}) : {1'b0, smp};
		rise     = 1'b0;
		measured = 1'b0;
		if (mag >= {2'b00, thr_q}) begin
			pos        = !neg && (smp != '0);
			rise       = pos && !sign_pos_q;
			sign_pos_q = pos;
		end
		if (rise) begin
			cross_cnt_q = cross_cnt_q + 4'd1;
			if (cross_cnt_q >= N_CYCLES) begin
				num         = 64'(N_CYCLES) * 64'(rate_q) * 64'd256;
				den         = 64'(smp_cnt_q) + 64'd1;
				quo         = num / den;
				held_freq_q = (quo > 64'(zcfc_pkg::FREQ_MAX)) ? zcfc_pkg::FREQ_MAX
				                                              : quo[zcfc_pkg::FREQ_W-1:0];
				cross_cnt_q = '0;
				smp_cnt_q   = '0;
				measured    = 1'b1;
			end
		end
		if (!measured && smp_cnt_q != '1)
			smp_cnt_q = smp_cnt_q + 1'b1;
		return held_freq_q;
	endfunction

	// Send one sample beat and record its expected frequency
	task automatic send_sample(input logic [zcfc_pkg::SAMPLE_W-1:0] smp);
		@(negedge clk);
		while (!calm && $urandom_range(0, 99) < STALL_PCT) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= smp;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		freq_expect_q.push_back(next_frequency(smp));
	endtask

	// Drop valid and hold until every expected beat has come out
	task automatic wait_idle();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (freq_expect_q.size() != 0)
			@(posedge clk);
	endtask

	// Write both registers while the block is idle
	task automatic write_regs(input logic [zcfc_pkg::THR_W-1:0] thr,
	                          input logic [zcfc_pkg::SR_W-1:0] rate);
		@(negedge clk);
		cfg_we   <= 1'b1;
		cfg_addr <= zcfc_pkg::REG_THRESHOLD;
		cfg_data <= zcfc_pkg::CFG_W'(thr);
		@(negedge clk);
		cfg_addr <= zcfc_pkg::REG_SAMPLE_RATE;
		cfg_data <= zcfc_pkg::CFG_W'(rate);
		@(negedge clk);
		cfg_we   <= 1'b0;
		thr_q    = thr;
		rate_q   = rate;
	endtask

	// Extremes of the sample and the threshold edges under reset settings
	task automatic test_reset_defaults();
		send_sample(16'h7FFF);
		send_sample(16'h8000);
		send_sample(16'h0000);
		send_sample(16'hFFFF);
		send_sample(16'h0001);
		send_sample(16'd999);
		send_sample(16'h0000 - 16'd999);
		send_sample(16'd1000);
		send_sample(16'h0000 - 16'd1000);
		send_sample(16'h8001);
		send_sample(16'h5555);
		send_sample(16'hAAAA);
	endtask

	// Zero threshold: every sample counts and zero reads as negative
	task automatic test_zero_threshold();
		wait_idle();
		write_regs(15'd0, zcfc_pkg::SR_RST);
		send_sample(16'h0000);
		send_sample(16'h0001);
		send_sample(16'h0000);
		send_sample(16'h0001);
		send_sample(16'hFFFF);
		send_sample(16'h0000);
	endtask

	// Largest threshold: only full-scale samples pass
	task automatic test_threshold_max();
		wait_idle();
		write_regs(15'h7FFF, zcfc_pkg::SR_RST);
		send_sample(16'h8001);
		send_sample(16'h7FFF);
		send_sample(16'h7FFE);
		send_sample(16'h8000);
		send_sample(16'h7FFF);
	endtask

	// Square-like waveforms with random levels, mixed with noise and small samples
	task automatic run_waveform(input int n_items);
		logic [zcfc_pkg::SAMPLE_W-1:0] smp;
		int unsigned                   amp;
		int unsigned                   lo;
		int                            half_len;
		int                            pos_run;
		int                            r;
		logic                          hi_half;
		lo       = (thr_q == 0) ? 1 : 32'(thr_q);
		hi_half  = 1'($urandom_range(0, 1));
		half_len = $urandom_range(1, 6);
		pos_run  = 0;
		amp      = $urandom_range(lo, 32767);
		for (int i = 0; i < n_items; i++) begin
			r = $urandom_range(0, 99);
			if (r < 8) begin
				smp = zcfc_pkg::SAMPLE_W'($urandom);
			end else if (r < 14 && thr_q != 0) begin
				smp = zcfc_pkg::SAMPLE_W'($urandom_range(0, thr_q - 1));
				if ($urandom_range(0, 1))
					smp = 16'h0000 - smp;
			end else begin
				if (hi_half)
					smp = zcfc_pkg::SAMPLE_W'(amp);
				else if ($urandom_range(0, 9) == 0)
					smp = 16'h8000;
				else if (thr_q == 0 && $urandom_range(0, 9) == 0)
					smp = 16'h0000;
				else
					smp = 16'h0000 - zcfc_pkg::SAMPLE_W'(amp);
				pos_run++;
				if (pos_run >= half_len) begin
					hi_half  = !hi_half;
					half_len = $urandom_range(1, 6);
					pos_run  = 0;
					amp      = $urandom_range(lo, 32767);
				end
			end
			send_sample(smp);
		end
	endtask

	// Random phases over several register settings, extremes among them
	task automatic test_random_phases();
		logic [zcfc_pkg::THR_W-1:0] thr_set[8];
		logic [zcfc_pkg::SR_W-1:0]  rate_set[8];
		thr_set[0] = zcfc_pkg::THR_RST;
		rate_set[0] = zcfc_pkg::SR_RST;
		thr_set[1] = 15'd1;
		rate_set[1] = 27'd1;
		thr_set[2] = 15'h7FFF;
		rate_set[2] = 27'd100000000;
		thr_set[3] = 15'd0;
		rate_set[3] = 27'd0;
		thr_set[4] = zcfc_pkg::THR_W'($urandom);
		rate_set[4] = zcfc_pkg::SR_W'($urandom);
		thr_set[5] = zcfc_pkg::THR_W'($urandom_range(0, 4000));
		rate_set[5] = '1;
		thr_set[6] = zcfc_pkg::THR_W'($urandom);
		rate_set[6] = zcfc_pkg::SR_W'($urandom_range(1, 200000));
		thr_set[7] = 15'd300;
		rate_set[7] = 27'd44100;
		for (int p = 0; p < 8; p++) begin
			wait_idle();
			write_regs(thr_set[p], rate_set[p]);
			calm = (p == 0);
			run_waveform(125);
		end
		calm = 1'b0;
	endtask

	// Sink side: stall at random except in the calm stretch
	always @(negedge clk) begin
		if (!arst_n)
			m_tready <= 1'b0;
		else
			m_tready <= calm || ($urandom_range(0, 99) >= STALL_PCT);
	end

	// Compare each frequency beat with the oldest expectation
	always @(posedge clk) begin
		logic [zcfc_pkg::FREQ_W-1:0] exp_freq;
		if (arst_n && m_tvalid && m_tready) begin
			if (freq_expect_q.size() == 0) begin
				$display("%0t: frequency beat with none expected, expected none, got %0d",
					$time, m_tdata);
				fail_count++;
			end else begin
				exp_freq = freq_expect_q.pop_front();
				if (m_tdata !== {2'b00, exp_freq}) begin
					$display("%0t: frequency mismatch, expected %0d, got %0d",
						$time, exp_freq, m_tdata);
					fail_count++;
				end
			end
		end
	end

	// Watchdog: end the run when no beat moves for too long
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !arst_n)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= IDLE_LIMIT) begin
			$display("[zero_crossing_frequency_counter_unit] ERROR");
			$finish;
		end
	end

	initial begin
		clk          = 1'b0;
		arst_n       = 1'b0;
		cfg_we       = 1'b0;
		cfg_addr     = zcfc_pkg::REG_THRESHOLD;
		cfg_data     = '0;
		s_tvalid     = 1'b0;
		s_tdata      = '0;
		calm         = 1'b0;
		thr_q        = zcfc_pkg::THR_RST;
		rate_q       = zcfc_pkg::SR_RST;
		sign_pos_q   = 1'b1;
		cross_cnt_q  = '0;
		smp_cnt_q    = '0;
		held_freq_q  = '0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_reset_defaults();
		test_zero_threshold();
		test_threshold_max();
		test_random_phases();

		wait_idle();
		repeat (TAIL_WAIT) @(posedge clk);
		if (fail_count == 0)
			$display("[zero_crossing_frequency_counter_unit] OK");
		else
			$display("[zero_crossing_frequency_counter_unit] ERROR");
		$finish;
	end

endmodule
